// ----- hw/rtl/tsel_pkg.sv -----
package tsel_pkg;

	localparam int unsigned CAPACITY_DEF  = 8;
	localparam int unsigned TAG_WIDTH_DEF = 16;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned KEY_W    = HOUR_W + MINUTE_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/tsel_if.sv -----
interface tsel_req_if import tsel_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [HOUR_W-1:0]   event_hour;
	logic [MINUTE_W-1:0] event_minute;
	logic [TAG_W-1:0]    event_tag;
	logic [IDX_W-1:0]    slot_index;

	modport source(output valid, opcode, event_hour, event_minute, event_tag, slot_index,
		input ready);
	modport sink(input valid, opcode, event_hour, event_minute, event_tag, slot_index,
		output ready);
endinterface

interface tsel_rsp_if import tsel_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    slot_position;
	logic [HOUR_W-1:0]   read_hour;
	logic [MINUTE_W-1:0] read_minute;
	logic [TAG_W-1:0]    read_tag;
	logic [COUNT_W-1:0]  entry_count;

	modport source(output valid, status, slot_position, read_hour, read_minute, read_tag,
		entry_count, input ready);
	modport sink(input valid, status, slot_position, read_hour, read_minute, read_tag,
		entry_count, output ready);
endinterface

// ----- hw/rtl/time_sorted_event_list.sv -----
// the result of an accepted transaction is registered and appears on rsp in the next cycle
// throughput: one transaction per cycle while rsp is not stalled; every cell compares and shifts in the same cycle
// a new request is taken while the previous result is being taken
// reset clears the fill count and the result valid; cell contents are unreset
module time_sorted_event_list_core import tsel_pkg::*; #(
	parameter int unsigned CAPACITY  = CAPACITY_DEF,
	parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tsel_req_if.sink   req,
	tsel_rsp_if.source rsp
);

	localparam int unsigned ENTRY_W = KEY_W + TAG_WIDTH;
	localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
	localparam int unsigned AT_W    = $clog2(CAPACITY);
	localparam int unsigned CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int unsigned RD_N    = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               accept;
	logic               full;
	logic               idx_ok;
	cell_ctl_t          ctl;
	logic [ENTRY_W-1:0] new_entry;
	logic [ENTRY_W-1:0] cell_entry [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_after;
	logic [CAPACITY-1:0] cell_first;
	logic [AT_W-1:0]    at_pos;
	logic [ENTRY_W-1:0] rd_entry;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [TAG_W-1:0]    tag_q;
	logic [COUNT_W-1:0]  count_out_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign idx_ok    = CMP_W'(req.slot_index) < CMP_W'(count_q);
	assign new_entry = {req.event_hour, req.event_minute, TAG_WIDTH'(req.event_tag)};

	assign ctl.ins = accept && (req.opcode == OP_INSERT) && !full;
	assign ctl.del = accept && (req.opcode == OP_DELETE) && idx_ok;
	assign ctl.idx = req.slot_index;

	genvar k;
	generate
		for (k = 0; k < CAPACITY; k++) begin : g_cell
			logic [ENTRY_W-1:0] left_e;
			logic [ENTRY_W-1:0] right_e;
			logic               left_a;

			assign cell_valid[k] = CNT_W'(k) < count_q;

			if (k == 0) begin : g_head
				assign left_e = new_entry;
				assign left_a = 1'b0;
				assign cell_first[k] = cell_after[k];
			end else begin : g_body
				assign left_e = cell_entry[k-1];
				assign left_a = cell_after[k-1];
				assign cell_first[k] = cell_after[k] && !cell_after[k-1];
			end

			if (k == CAPACITY - 1) begin : g_tail
				assign right_e = cell_entry[k];
			end else begin : g_mid
				assign right_e = cell_entry[k+1];
			end

			tsel_cell #(
				.CELL_IDX(k),
				.ENTRY_W (ENTRY_W)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid      (cell_valid[k]),
				.new_entry  (new_entry),
				.left_entry (left_e),
				.left_after (left_a),
				.right_entry(right_e),
				.entry      (cell_entry[k]),
				.after      (cell_after[k])
			);
		end
	endgenerate

	always_comb begin
		at_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_first[i]) begin
				at_pos = at_pos | AT_W'(i);
			end
		end
	end

	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (req.slot_index == IDX_W'(i)) begin
				rd_entry = cell_entry[i];
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= ST_OK;
			pos_q       <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			tag_q       <= '0;
			count_out_q <= COUNT_W'(count_nxt);
			unique case (req.opcode)
				OP_INSERT: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						pos_q <= POS_W'(at_pos);
					end
				end
				OP_DELETE: begin
					pos_q <= req.slot_index;
					if (!idx_ok) begin
						status_q <= ST_RANGE;
					end
				end
				OP_READ: begin
					pos_q <= req.slot_index;
					if (!idx_ok) begin
						status_q <= ST_RANGE;
					end else begin
						hour_q   <= rd_entry[ENTRY_W-1 -: HOUR_W];
						minute_q <= rd_entry[ENTRY_W-HOUR_W-1 -: MINUTE_W];
						tag_q    <= TAG_W'(rd_entry[TAG_WIDTH-1:0]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.slot_position = pos_q;
	assign rsp.read_hour     = hour_q;
	assign rsp.read_minute   = minute_q;
	assign rsp.read_tag      = tag_q;
	assign rsp.entry_count   = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == OP_INSERT && !full) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted transaction gave no result");

	a_full_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.slot_position == '0 && rsp.read_tag == '0))
		else $error("full status with nonzero fields");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> $onehot(cell_first))
		else $error("insert position not unique");

endmodule

// ----- hw/rtl/tsel_cell.sv -----
module tsel_cell import tsel_pkg::*; #(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned ENTRY_W  = KEY_W + TAG_WIDTH_DEF
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               valid,
	input  logic [ENTRY_W-1:0] new_entry,
	input  logic [ENTRY_W-1:0] left_entry,
	input  logic               left_after,
	input  logic [ENTRY_W-1:0] right_entry,
	output logic [ENTRY_W-1:0] entry,
	output logic               after
);

	logic [ENTRY_W-1:0] entry_q;
	logic               del_shift;

	// set for cells that are empty or hold a strictly later time than the new one
	assign after = !valid || (entry_q[ENTRY_W-1 -: KEY_W] > new_entry[ENTRY_W-1 -: KEY_W]);

	generate
		if (CELL_IDX >= (1 << IDX_W)) begin : g_far
			assign del_shift = 1'b1;
		end else begin : g_near
			assign del_shift = IDX_W'(CELL_IDX) >= ctl.idx;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ctl.ins && after) begin
			entry_q <= left_after ? left_entry : new_entry;
		end else if (ctl.del && del_shift) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
